@@ hw/rtl/lru_page_replacement_assert.svh @@
// assertion macros for the lru page replacement block
// no dependencies; included by the modules that carry assertions
`ifndef LRU_PAGE_REPLACEMENT_ASSERT_SVH
`define LRU_PAGE_REPLACEMENT_ASSERT_SVH
`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LRUPR_ASSERT(name, clk, rst_n, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error(msg);
// property that must hold in the cycle after its antecedent
`define LRUPR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LRUPR_ASSERT(name, clk, rst_n, expr, msg)
`define LRUPR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hw/rtl/lrupr_pkg.sv @@
// shared types and constants for the lru page replacement block
// no dependencies; imported by controller, datapath and top level
package lrupr_pkg;

	localparam int MAX_FRAMES_DEF = 16;
	localparam int PAGE_BITS      = 16;
	localparam int CFG_W          = 5;
	localparam int FIDX_W         = 4;
	localparam int FAULT_W        = 16;

	localparam logic [CFG_W-1:0]   FRAMES_RESET = 5'd16;
	localparam logic [FAULT_W-1:0] FAULT_MAX    = 16'hFFFF;

	typedef struct packed {
		logic [PAGE_BITS-1:0] page_number;
		logic                 new_run;
	} in_item_t;

	typedef struct packed {
		logic                 hit;
		logic [FIDX_W-1:0]    frame_index;
		logic                 evicted_valid;
		logic [PAGE_BITS-1:0] evicted_page;
		logic [FAULT_W-1:0]   fault_total;
	} out_item_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_UPDATE
	} lrupr_state_t;

	typedef struct packed {
		logic start;
		logic scan;
		logic update;
	} lrupr_cmd_t;

	typedef struct packed {
		logic scan_done;
	} lrupr_status_t;

endpackage

@@ hw/rtl/lrupr_ctrl.sv @@
// controller state machine: accept, frame scan, update and result handoff
// depends on lrupr_pkg and lru_page_replacement_assert.svh
`include "lru_page_replacement_assert.svh"
module lrupr_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  logic                    out_ready,
	input  lrupr_pkg::lrupr_status_t status,
	output lrupr_pkg::lrupr_cmd_t    cmd
);
	import lrupr_pkg::*;

	lrupr_state_t state_q, state_d;
	logic         out_valid_q;
	logic         can_update;

	assign can_update = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_SCAN;
			end
			S_SCAN: begin
				if (status.scan_done) state_d = S_UPDATE;
			end
			S_UPDATE: begin
				if (can_update) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_ready   = 1'b0;
		cmd.start  = 1'b0;
		cmd.scan   = 1'b0;
		cmd.update = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready  = 1'b1;
				cmd.start = in_valid;
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
			end
			S_UPDATE: begin
				cmd.update = can_update;
			end
			default: ;
		endcase
	end

	// result flag: set when a result is written, cleared when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	`LRUPR_ASSERT(a_update_no_overwrite, clk, arst_n, !cmd.update || !out_valid_q || out_ready, "result overwritten before taken")
	`LRUPR_ASSERT_NEXT(a_start_enters_scan, clk, arst_n, cmd.start, state_q == S_SCAN, "accepted item did not start a scan")
	`LRUPR_ASSERT(a_valid_from_update, clk, arst_n, !$rose(out_valid_q) || $past(cmd.update), "result flag rose without an update")

endmodule

@@ hw/rtl/lrupr_datapath.sv @@
// datapath: page memory, recency ranks, scan pipeline, counters and result register
// depends on lrupr_pkg and lru_page_replacement_assert.svh
`include "lru_page_replacement_assert.svh"
module lrupr_datapath #(
	parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0]   cfg_wdata,
	input  lrupr_pkg::in_item_t           in_data,
	input  lrupr_pkg::lrupr_cmd_t         cmd,
	output lrupr_pkg::lrupr_status_t      status,
	output lrupr_pkg::out_item_t          out_data
);
	import lrupr_pkg::*;

	localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int CNT_W = $clog2(MAX_FRAMES + 1);
	localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	logic [PAGE_BITS-1:0] page_mem [MAX_FRAMES];
	logic [IDX_W-1:0]     rank_q   [MAX_FRAMES];

	logic [CFG_W-1:0]     frames_q;
	logic [CNT_W-1:0]     filled_q;
	logic [FAULT_W-1:0]   fault_q;
	logic [PAGE_BITS-1:0] page_q;

	// scan pipeline
	logic [CNT_W-1:0]     cnt_q;
	logic                 vld_s1;
	logic [IDX_W-1:0]     idx_s1;
	logic [IDX_W-1:0]     rank_s1;
	logic [PAGE_BITS-1:0] rd_page_s1;

	logic                 found_q;
	logic [IDX_W-1:0]     match_idx_q;
	logic [IDX_W-1:0]     match_rank_q;
	logic [IDX_W-1:0]     old_idx_q;
	logic [IDX_W-1:0]     old_rank_q;
	logic [PAGE_BITS-1:0] old_page_q;

	out_item_t            res_q;

	logic                 issue;
	logic                 clear_run;
	logic [LIM_W-1:0]     cfg_ext;
	logic [LIM_W-1:0]     limit;
	logic                 do_fill;
	logic                 ev_valid;
	logic [IDX_W-1:0]     upd_frame;
	logic [FAULT_W-1:0]   fault_next;

	assign clear_run        = cmd.start && in_data.new_run;
	assign issue            = cmd.scan && (cnt_q < filled_q);
	assign status.scan_done = (cnt_q >= filled_q) && !vld_s1;

	// effective frame limit, clamped to 1..MAX_FRAMES
	always_comb begin
		cfg_ext = LIM_W'(frames_q);
		if (cfg_ext == '0) begin
			limit = LIM_W'(1);
		end else if (cfg_ext > LIM_W'(MAX_FRAMES)) begin
			limit = LIM_W'(MAX_FRAMES);
		end else begin
			limit = cfg_ext;
		end
	end

	assign do_fill    = !found_q && (LIM_W'(filled_q) < limit);
	assign ev_valid   = !found_q && !do_fill;
	assign fault_next = (!found_q && fault_q != FAULT_MAX) ? fault_q + 1'b1 : fault_q;

	always_comb begin
		priority if (found_q) begin
			upd_frame = match_idx_q;
		end else if (do_fill) begin
			upd_frame = filled_q[IDX_W-1:0];
		end else begin
			upd_frame = old_idx_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			frames_q <= cfg_wdata;
		end
	end

	// page memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.update && !found_q) begin
			page_mem[upd_frame] <= page_q;
		end
		if (issue) begin
			rd_page_s1 <= page_mem[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q <= in_data.page_number;
		end
		if (issue) begin
			idx_s1  <= cnt_q[IDX_W-1:0];
			rank_s1 <= rank_q[cnt_q[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else if (cmd.start) begin
			cnt_q   <= '0;
			vld_s1  <= 1'b0;
			found_q <= 1'b0;
		end else begin
			vld_s1 <= issue;
			if (issue) cnt_q <= cnt_q + 1'b1;
			if (vld_s1 && !found_q && rd_page_s1 == page_q) found_q <= 1'b1;
		end
	end

	// match and oldest tracking, first frame seeds the oldest
	always_ff @(posedge clk) begin
		if (vld_s1) begin
			if (!found_q && rd_page_s1 == page_q) begin
				match_idx_q  <= idx_s1;
				match_rank_q <= rank_s1;
			end
			if (idx_s1 == '0 || rank_s1 > old_rank_q) begin
				old_idx_q  <= idx_s1;
				old_rank_q <= rank_s1;
				old_page_q <= rd_page_s1;
			end
		end
	end

	// rank update: chosen frame to zero, filled frames below the bound age by one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < MAX_FRAMES; k++) rank_q[k] <= '0;
		end else if (clear_run) begin
			for (int k = 0; k < MAX_FRAMES; k++) rank_q[k] <= '0;
		end else if (cmd.update) begin
			for (int k = 0; k < MAX_FRAMES; k++) begin
				if (IDX_W'(k) == upd_frame) begin
					rank_q[k] <= '0;
				end else if (CNT_W'(k) < filled_q &&
				             (!found_q || rank_q[k] < match_rank_q)) begin
					rank_q[k] <= rank_q[k] + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
			fault_q  <= '0;
		end else if (clear_run) begin
			filled_q <= '0;
			fault_q  <= '0;
		end else if (cmd.update) begin
			fault_q <= fault_next;
			if (do_fill) filled_q <= filled_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			res_q.hit           <= found_q;
			res_q.frame_index   <= FIDX_W'(upd_frame);
			res_q.evicted_valid <= ev_valid;
			res_q.evicted_page  <= ev_valid ? old_page_q : '0;
			res_q.fault_total   <= fault_next;
		end
	end

	assign out_data = res_q;

	`LRUPR_ASSERT(a_filled_bound, clk, arst_n, filled_q <= CNT_W'(MAX_FRAMES), "filled count above frame count")
	`LRUPR_ASSERT_NEXT(a_miss_counts, clk, arst_n, cmd.update && !found_q, fault_q != '0, "miss left fault count at zero")
	`LRUPR_ASSERT(a_match_in_range, clk, arst_n, !found_q || CNT_W'(match_idx_q) < filled_q, "match outside filled frames")

endmodule

@@ hw/rtl/lru_page_replacement.sv @@
// top level of the lru page replacement block: controller plus datapath
// depends on lrupr_pkg, lrupr_ctrl and lrupr_datapath
//
//  channel   direction  handshake            payload
//  in        input      in_valid/in_ready    in_data   (page_number, new_run)
//  out       output     out_valid/out_ready  out_data  (hit, frame_index, evicted_*, fault_total)
//  cfg       input      cfg_we               cfg_wdata (frames_in_use)
//
// one item in flight; from accept to next accept an item passes through accept, one read
// per filled frame, read drain, done check and update, the scan paced by the single read
// port of the page memory; a new item is accepted while the
// previous result waits in the output register, its update holds until that result is taken
// reset: ranks, filled count and fault count cleared, frames_in_use set to 16, no clearing pass
// new_run clears ranks, filled count and fault count at accept, in the same cycle
module lru_page_replacement #(
	parameter int MAX_FRAMES = lrupr_pkg::MAX_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  lrupr_pkg::in_item_t         in_data,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lrupr_pkg::out_item_t        out_data,
	input  logic                        cfg_we,
	input  logic [lrupr_pkg::CFG_W-1:0] cfg_wdata
);
	import lrupr_pkg::*;

	// command and status between controller and datapath
	lrupr_cmd_t    cmd;
	lrupr_status_t status;

	// sequencer: idle, scan over filled frames, update
	lrupr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// page memory, recency ranks, counters and result register
	lrupr_datapath #(
		.MAX_FRAMES (MAX_FRAMES)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_data   (in_data),
		.cmd       (cmd),
		.status    (status),
		.out_data  (out_data)
	);

endmodule
